// ===== rtl/core/sdf_pkg.sv =====
`default_nettype none

package sdf_pkg;

  localparam int unsigned MAX_FIELD  = 40;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  localparam int unsigned DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BCD_W  = 4 * DIGITS;
  localparam int unsigned FW     = $clog2(MAX_FIELD + 2);
  localparam int unsigned DW     = $clog2(DIGITS + 1);
  localparam int unsigned BW     = $clog2(VALUE_BITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_JUSTIFY  = 3'd0,
    REG_ZERO_PAD      = 3'd1,
    REG_FORCE_PLUS    = 3'd2,
    REG_SPACE_SIGN    = 3'd3,
    REG_HAS_PRECISION = 3'd4,
    REG_FIELD_WIDTH   = 3'd5,
    REG_MIN_DIGITS    = 3'd6
  } sdf_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_LAYOUT,
    S_EMIT
  } sdf_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/sdf_if.sv =====
`default_nettype none

interface sdf_in_if;
  import sdf_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sdf_out_if;
  import sdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface sdf_cfg_if;
  import sdf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/signed_decimal_formatter.sv =====
`default_nettype none

// Renders each signed input value as printf "%d" text under the flags held in
// the configuration registers, one ASCII character per output transfer, with
// last_char set on the final character; a zero value with precision 0, no sign
// and width 0 produces no transfer at all. Width and precision above MAX_FIELD
// are treated as MAX_FIELD. One value is processed at a time: after the input
// transfer the magnitude goes through a bit-serial binary-to-BCD converter,
// leading zero digits are then stripped one per cycle, a layout step computes
// the padding, and the characters follow at one per cycle through the output
// register while the receiver does not stall. The input is ready again once
// the final character sits in the output register. Configuration writes are
// accepted in every cycle and must only be made while no value is in flight.
module signed_decimal_formatter (
  input  logic            clk_i,
  input  logic            rst_ni,
  sdf_cfg_if.sink         cfg_i,
  sdf_in_if.sink          in_i,
  sdf_out_if.source       out_o
);
  import sdf_pkg::*;

  logic                  left_q, zero_q, plus_q, space_q, prec_on_q;
  logic [CFG_DATA_W-1:0] width_q, prec_q;

  sdf_state_e            state_q, state_d;
  logic [BW-1:0]         bit_cnt_q, bit_cnt_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [DW-1:0]         ndig_q, ndig_d;
  logic [FW-1:0]         lead_q, lead_d;
  logic [FW-1:0]         zeros_q, zeros_d;
  logic [FW-1:0]         trail_q, trail_d;
  logic [FW-1:0]         rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic                  sign_on_q, sign_on_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [VALUE_BITS-1:0] raw;
  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_digit;
  logic [FW-1:0]         width_sat, prec_sat, ndig_e, body, need, pad;
  logic [DW-1:0]         ndig_eff;
  logic                  zpad_mode, can_load;
  logic [CHAR_W-1:0]     sign_char;

  assign cfg_i.ready     = 1'b1;
  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = out_char_q;
  assign out_o.last_char = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= 1'b0;
      zero_q    <= 1'b0;
      plus_q    <= 1'b0;
      space_q   <= 1'b0;
      prec_on_q <= 1'b0;
      width_q   <= '0;
      prec_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LEFT_JUSTIFY:  left_q    <= cfg_i.data[0];
        REG_ZERO_PAD:      zero_q    <= cfg_i.data[0];
        REG_FORCE_PLUS:    plus_q    <= cfg_i.data[0];
        REG_SPACE_SIGN:    space_q   <= cfg_i.data[0];
        REG_HAS_PRECISION: prec_on_q <= cfg_i.data[0];
        REG_FIELD_WIDTH:   width_q   <= cfg_i.data;
        REG_MIN_DIGITS:    prec_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign raw       = in_i.value[VALUE_BITS-1:0];
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign width_sat = (width_q > CFG_DATA_W'(MAX_FIELD)) ? FW'(MAX_FIELD) : FW'(width_q);
  assign prec_sat  = (prec_q > CFG_DATA_W'(MAX_FIELD)) ? FW'(MAX_FIELD) : FW'(prec_q);
  assign ndig_eff  = (prec_on_q && prec_sat == '0 && top_digit == 4'd0) ? '0 : ndig_q;
  assign ndig_e    = FW'(ndig_eff);
  assign body      = (prec_on_q && prec_sat > ndig_e) ? prec_sat : ndig_e;
  assign need      = body + FW'(sign_on_q);
  assign pad       = (width_sat > need) ? width_sat - need : '0;
  assign zpad_mode = !left_q && zero_q && !prec_on_q;
  assign can_load  = !out_valid_q || out_o.ready;
  assign sign_char = neg_q ? CHAR_MINUS : (plus_q ? CHAR_PLUS : CHAR_SPACE);

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_cnt_q  <= bit_cnt_d;
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    ndig_q     <= ndig_d;
    lead_q     <= lead_d;
    zeros_q    <= zeros_d;
    trail_q    <= trail_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    sign_on_q  <= sign_on_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    ndig_d      = ndig_q;
    lead_d      = lead_q;
    zeros_d     = zeros_q;
    trail_d     = trail_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    sign_on_d   = sign_on_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          neg_d     = raw[VALUE_BITS-1];
          mag_d     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
          sign_on_d = raw[VALUE_BITS-1] || plus_q || space_q;
          bcd_d     = '0;
          bit_cnt_d = BW'(VALUE_BITS);
          state_d   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d     = {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
        mag_d     = mag_q << 1;
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == BW'(1)) begin
          ndig_d  = DW'(DIGITS);
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (ndig_q > DW'(1) && top_digit == 4'd0) begin
          bcd_d  = bcd_q << 4;
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = S_LAYOUT;
        end
      end
      S_LAYOUT: begin
        ndig_d  = ndig_eff;
        lead_d  = (!left_q && !zpad_mode) ? pad : '0;
        trail_d = left_q ? pad : '0;
        zeros_d = (body - ndig_e) + (zpad_mode ? pad : '0);
        rem_d   = pad + need;
        state_d = ((pad + need) == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_last_d  = (rem_q == FW'(1));
          rem_d       = rem_q - 1'b1;
          if (lead_q != '0) begin
            out_char_d = CHAR_SPACE;
            lead_d     = lead_q - 1'b1;
          end else if (sign_on_q) begin
            out_char_d = sign_char;
            sign_on_d  = 1'b0;
          end else if (zeros_q != '0) begin
            out_char_d = CHAR_ZERO;
            zeros_d    = zeros_q - 1'b1;
          end else if (ndig_q != '0) begin
            out_char_d = CHAR_ZERO + {4'd0, top_digit};
            bcd_d      = bcd_q << 4;
            ndig_d     = ndig_q - 1'b1;
          end else begin
            out_char_d = CHAR_SPACE;
            trail_d    = trail_q - 1'b1;
          end
          if (rem_q == FW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_conv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> (bit_cnt_q != '0))
    else $error("conversion running with an exhausted bit count");

  a_norm_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NORM) |-> (ndig_q != '0))
    else $error("digit count dropped to zero while stripping leading zeros");

  a_emit_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |->
      ((FW+2)'(rem_q) == (FW+2)'(lead_q) + (FW+2)'(zeros_q) + (FW+2)'(trail_q)
                         + (FW+2)'(ndig_q) + (FW+2)'(sign_on_q)))
    else $error("remaining character count disagrees with the segment counts");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && lead_q == '0 && !sign_on_q && zeros_q == '0 && ndig_q != '0)
      |-> (top_digit <= 4'd9))
    else $error("emitted digit is not a decimal digit");

  a_accept_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !(out_valid_q && !out_last_q))
    else $error("new value taken while a rendering is still incomplete");

endmodule

`default_nettype wire

// ===== test/tb_signed_decimal_formatter.sv =====
`default_nettype none

module tb_signed_decimal_formatter;
  import sdf_pkg::*;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned RANDOM_ITEMS  = 460;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                  left_just;
    logic                  zero_pad;
    logic                  force_plus;
    logic                  space_sign;
    logic                  has_prec;
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] digits;
  } fmt_cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  typedef struct {
    fmt_cfg_t           cfg;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    string              text;
  } dir_row_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_BURSTY
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  sdf_in_if  in_bus ();
  sdf_out_if out_bus ();
  sdf_cfg_if cfg_bus ();

  signed_decimal_formatter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  fmt_cfg_t    fmt = '0;
  char_beat_t  pending_chars[$];
  char_beat_t  want;
  dir_row_t    dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 1;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic fmt_cfg_t mk_fmt(bit l, bit z, bit p, bit s, bit pr, int unsigned w,
                                      int unsigned d);
    fmt_cfg_t c;
    c.left_just  = l;
    c.zero_pad   = z;
    c.force_plus = p;
    c.space_sign = s;
    c.has_prec   = pr;
    c.width      = CFG_DATA_W'(w);
    c.digits     = CFG_DATA_W'(d);
    return c;
  endfunction

  function automatic void queue_line(input byte unsigned line[$]);
    foreach (line[i]) begin
      pending_chars.push_back('{code: line[i], last: (i == line.size() - 1)});
    end
  endfunction

  function automatic void queue_text(input string text);
    byte unsigned line[$];
    for (int i = 0; i < text.len(); i++) begin
      line.push_back(text[i]);
    end
    queue_line(line);
  endfunction

  // Builds [left spaces][sign][zero fill][digits][right spaces] for one value.
  function automatic void predict_chars(input logic [VALUE_W-1:0] value);
    logic [63:0]       span = 64'd1 << VALUE_BITS;
    logic [63:0]       raw = 64'(value) & (span - 64'd1);
    logic              neg = raw[VALUE_BITS-1];
    logic [63:0]       mag = neg ? span - raw : raw;
    int unsigned       width = (fmt.width > MAX_FIELD) ? MAX_FIELD : fmt.width;
    int unsigned       prec = (fmt.digits > MAX_FIELD) ? MAX_FIELD : fmt.digits;
    bit                zero_fill = !fmt.left_just && fmt.zero_pad && !fmt.has_prec;
    logic [CHAR_W-1:0] sign_char = CHAR_MINUS;
    bit                sign_on = 1'b1;
    byte unsigned      digit_chars[$];
    byte unsigned      line[$];
    int unsigned       body;
    int unsigned       pad;
    if (!(fmt.has_prec && prec == 0 && mag == 0)) begin
      do begin
        digit_chars.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
    end
    if (!neg) begin
      if (fmt.force_plus) sign_char = CHAR_PLUS;
      else if (fmt.space_sign) sign_char = CHAR_SPACE;
      else sign_on = 1'b0;
    end
    body = digit_chars.size();
    if (fmt.has_prec && prec > body) body = prec;
    pad = (width > body + sign_on) ? width - body - sign_on : 0;
    if (!fmt.left_just && !zero_fill) repeat (pad) line.push_back(CHAR_SPACE);
    if (sign_on) line.push_back(sign_char);
    if (zero_fill) repeat (pad) line.push_back(CHAR_ZERO);
    repeat (body - digit_chars.size()) line.push_back(CHAR_ZERO);
    foreach (digit_chars[i]) line.push_back(digit_chars[i]);
    if (fmt.left_just) repeat (pad) line.push_back(CHAR_SPACE);
    queue_line(line);
  endfunction

  function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LEFT_JUSTIFY: begin
        fmt.left_just = data[0];
      end
      REG_ZERO_PAD: begin
        fmt.zero_pad = data[0];
      end
      REG_FORCE_PLUS: begin
        fmt.force_plus = data[0];
      end
      REG_SPACE_SIGN: begin
        fmt.space_sign = data[0];
      end
      REG_HAS_PRECISION: begin
        fmt.has_prec = data[0];
      end
      REG_FIELD_WIDTH: begin
        fmt.width = data;
      end
      REG_MIN_DIGITS: begin
        fmt.digits = data;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    note_reg_write(idx, data);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // The upper data bits of the one-bit registers are don't-care and get random values.
  task automatic write_format(input fmt_cfg_t c);
    write_reg(REG_LEFT_JUSTIFY, {5'($urandom), c.left_just});
    write_reg(REG_ZERO_PAD, {5'($urandom), c.zero_pad});
    write_reg(REG_FORCE_PLUS, {5'($urandom), c.force_plus});
    write_reg(REG_SPACE_SIGN, {5'($urandom), c.space_sign});
    write_reg(REG_HAS_PRECISION, {5'($urandom), c.has_prec});
    write_reg(REG_FIELD_WIDTH, c.width);
    write_reg(REG_MIN_DIGITS, c.digits);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  task automatic wait_drained(input int unsigned extra);
    in_bus.valid = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value, input bit typed, input string text);
    in_bus.valid = 1'b1;
    in_bus.value = value;
    do @(posedge clk_i); while (!in_bus.ready);
    if (typed) queue_text(text);
    else predict_chars(value);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_bus.valid = 1'b0;
      in_bus.value = VALUE_W'($urandom);
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_field();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_DATA_W'(MAX_FIELD);
      2: return '1;
      3: return CFG_DATA_W'($urandom_range(0, 63));
      default: return CFG_DATA_W'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic fmt_cfg_t pick_format();
    fmt_cfg_t c;
    c.left_just  = $urandom_range(0, 1);
    c.zero_pad   = $urandom_range(0, 1);
    c.force_plus = $urandom_range(0, 1);
    c.space_sign = $urandom_range(0, 1);
    c.has_prec   = $urandom_range(0, 1);
    c.width      = pick_field();
    c.digits     = pick_field();
    return c;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned        pow10 = 1;
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v = VALUE_W'(int'($urandom_range(0, 40)) - 20);
      end
      3: begin
        v = $urandom_range(0, 1) ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end
      4: begin
        repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
        v = VALUE_W'(pow10 - $urandom_range(0, 1));
        if ($urandom_range(0, 1)) v = -v;
      end
      5: begin
        v = '0;
      end
      default: begin
        v = VALUE_W'($urandom);
      end
    endcase
    return v;
  endfunction

  function automatic void build_rows();
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 0, 0, 0), 32'd0, 1'b1, "0"});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 0, 0, 0), 32'h7FFF_FFFF, 1'b1, "2147483647"});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 0, 0, 0), 32'h8000_0000, 1'b1, "-2147483648"});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 0, 0, 0), 32'hFFFF_FFFF, 1'b1, "-1"});
    dir_rows.push_back('{mk_fmt(0, 0, 1, 1, 0, 0, 0), 32'd5, 1'b1, "+5"});
    dir_rows.push_back('{mk_fmt(0, 0, 1, 1, 0, 0, 0), -32'sd5, 1'b1, "-5"});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 1, 0, 0, 0), 32'd7, 1'b1, " 7"});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 1, 0, 0), 32'd0, 1'b1, ""});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 1, 3, 0), 32'd0, 1'b1, "   "});
    dir_rows.push_back('{mk_fmt(0, 0, 1, 0, 1, 0, 0), 32'd0, 1'b1, "+"});
    dir_rows.push_back('{mk_fmt(0, 1, 0, 0, 0, 8, 0), -32'sd42, 1'b1, "-0000042"});
    dir_rows.push_back('{mk_fmt(1, 1, 0, 0, 0, 6, 0), 32'd42, 1'b1, "42    "});
    dir_rows.push_back('{mk_fmt(0, 1, 0, 0, 1, 8, 4), 32'd42, 1'b1, "    0042"});
    dir_rows.push_back('{mk_fmt(0, 1, 1, 0, 0, 5, 0), 32'd3, 1'b1, "+0003"});
    dir_rows.push_back('{mk_fmt(0, 1, 0, 0, 0, 3, 0), -32'sd12345, 1'b1, "-12345"});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 0, 12, 0), 32'h8000_0000, 1'b1, " -2147483648"});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 1, 0, 12), 32'h8000_0000, 1'b1, "-002147483648"});
    dir_rows.push_back('{mk_fmt(1, 0, 0, 0, 0, 63, 0), 32'd1, 1'b0, ""});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 1, 40, 63), 32'h8000_0000, 1'b0, ""});
    dir_rows.push_back('{mk_fmt(0, 1, 0, 1, 0, 63, 0), 32'd123, 1'b0, ""});
    dir_rows.push_back('{mk_fmt(1, 0, 1, 0, 1, 10, 5), -32'sd9, 1'b0, ""});
    dir_rows.push_back('{mk_fmt(1, 1, 1, 1, 1, 63, 63), 32'h7FFF_FFFF, 1'b0, ""});
    dir_rows.push_back('{mk_fmt(0, 0, 0, 0, 0, 0, 0), 32'd0, 1'b1, "0"});
  endfunction

  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(30, 300);
    end
    rx_mode_left--;
    if (rx_stall_left != 0) begin
      out_bus.ready = 1'b0;
      rx_stall_left--;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          out_bus.ready = 1'b1;
        end
        RX_COIN: begin
          out_bus.ready = $urandom_range(0, 1);
        end
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(1, 12);
            out_bus.ready = 1'b0;
          end else begin
            out_bus.ready = 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("char 0x%02h arrived with nothing pending",
                                  out_bus.char_code));
      end else begin
        want = pending_chars.pop_front();
        if (out_bus.char_code !== want.code) begin
          report_mismatch($sformatf("char_code 0x%02h, want 0x%02h", out_bus.char_code,
                                    want.code));
        end
        if (out_bus.last_char !== want.last) begin
          report_mismatch($sformatf("last_char %b, want %b on char 0x%02h", out_bus.last_char,
                                    want.last, want.code));
        end
      end
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_signed_decimal_formatter failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_items;
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    out_bus.ready = 1'b0;
    build_rows();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != fmt) begin
        wait_drained(SETTLE_CYCLES);
        write_format(dir_rows[i].cfg);
      end
      send_value(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].text);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained(SETTLE_CYCLES);
      write_format(pick_format());
      phase_items = $urandom_range(8, 40);
      repeat (phase_items) begin
        if ($urandom_range(0, 24) == 0) wait_drained(0);
        send_value(pick_value(), 1'b0, "");
        sent++;
      end
    end

    wait_drained(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("tb_signed_decimal_formatter passed");
    end else begin
      $display("tb_signed_decimal_formatter failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
